// ===== sv/mie_pkg.sv =====
// shared types and constants for the modular inverse block
`timescale 1ns / 1ps

package mie_pkg;

	// operand width of value, modulus and results
	localparam int WIDTH = 32;
	// bits of the divider step counter
	localparam int CNT_W = $clog2(WIDTH);

	// input request
	typedef struct packed {
		logic [WIDTH-1:0] value;
		logic [WIDTH-1:0] modulus;
	} mie_req_t;

	// result
	typedef struct packed {
		logic [WIDTH-1:0] inverse;
		logic [WIDTH-1:0] common_divisor;
		logic             zero_value;
	} mie_res_t;

	// per-cycle status from the divider to the sequencer
	typedef struct packed {
		logic step;
		logic qbit;
		logic last;
	} mie_div_status_t;

endpackage

// ===== sv/mie_div.sv =====
// restoring divider, one quotient bit per cycle, msb first
`timescale 1ns / 1ps

module mie_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [mie_pkg::WIDTH-1:0]  numer,
	input  logic [mie_pkg::WIDTH-1:0]  denom,
	output mie_pkg::mie_div_status_t   status,
	output logic [mie_pkg::WIDTH-1:0]  rem
);
	import mie_pkg::*;

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] num_q;
	logic [WIDTH-1:0] den_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             ge;
	logic [WIDTH-1:0] rem_nxt;

	// shift in next dividend bit and try the subtraction
	always_comb begin
		trial   = {rem_q, num_q[WIDTH-1]};
		diff    = trial - {1'b0, den_q};
		ge      = (trial >= {1'b0, den_q});
		rem_nxt = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
	end

	assign status.step = run_q;
	assign status.qbit = ge;
	assign status.last = run_q && (cnt_q == '0);
	assign rem         = rem_nxt;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(WIDTH - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[WIDTH-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

endmodule

// ===== sv/modular_inverse_ext_euclid.sv =====
// modular inverse by extended euclid: sequencer, coefficient datapath, result
//
//  channel   ports                      direction  accepted when
//  request   start, request, busy       in         start && !busy
//  result    done, result               out        done (one cycle)
//
// each euclid step is a check, a divider run over WIDTH quotient bits and a
// coefficient update; unless the modulus is zero, a final divider run then
// reduces the coefficient, and the result follows. the running time is set
// by the single bit-serial divider. a zero value goes straight to done.
// busy is high from acceptance until done; reset clears the sequencer and the divider control only.
// the receiver cannot stall: done is a single-cycle strobe.
`timescale 1ns / 1ps

module modular_inverse_ext_euclid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mie_pkg::mie_req_t request,
	output logic              busy,
	output logic              done,
	output mie_pkg::mie_res_t result
);
	import mie_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_RED  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]       state_q;
	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] r_old_q;
	logic [WIDTH-1:0] r_cur_q;
	logic [WIDTH-1:0] mag_old_q;
	logic [WIDTH-1:0] mag_cur_q;
	logic [WIDTH-1:0] acc_q;
	logic             neg_old_q;
	logic             neg_cur_q;
	mie_res_t         res_q;

	logic             div_load;
	logic [WIDTH-1:0] div_numer;
	logic [WIDTH-1:0] div_denom;
	mie_div_status_t  div_st;
	logic [WIDTH-1:0] div_rem;
	logic [WIDTH-1:0] acc_nxt;

	// shared divider
	mie_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (div_load),
		.numer  (div_numer),
		.denom  (div_denom),
		.status (div_st),
		.rem    (div_rem)
	);

	// divider launch: euclid step or final reduction of the coefficient
	always_comb begin
		div_load  = (state_q == ST_CHK) && ((r_cur_q != '0) || (m_q != '0));
		div_numer = (r_cur_q != '0) ? r_old_q : mag_old_q;
		div_denom = (r_cur_q != '0) ? r_cur_q : m_q;
	end

	// horner accumulation of q * mag_cur, one quotient bit a cycle
	assign acc_nxt = {acc_q[WIDTH-2:0], 1'b0} + (div_st.qbit ? mag_cur_q : '0);

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_DONE);
	assign result = res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= (request.value == '0) ? ST_DONE : ST_CHK;
					end
				end
				ST_CHK: begin
					if (r_cur_q != '0) begin
						state_q <= ST_DIV;
					end else if (m_q != '0) begin
						state_q <= ST_RED;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_st.last) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD:  state_q <= ST_CHK;
				ST_RED: begin
					if (div_st.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// euclid registers and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				m_q       <= request.modulus;
				r_old_q   <= request.modulus;
				r_cur_q   <= request.value;
				mag_old_q <= '0;
				mag_cur_q <= WIDTH'(1);
				neg_old_q <= 1'b0;
				neg_cur_q <= 1'b0;
				res_q     <= '{inverse: '0, common_divisor: request.modulus,
				               zero_value: 1'b1};
			end
			ST_CHK: begin
				acc_q <= '0;
				// modulus zero: no reduction of the coefficient
				res_q <= '{inverse: mag_old_q, common_divisor: r_old_q,
				           zero_value: 1'b0};
			end
			ST_DIV: begin
				if (div_st.step) begin
					acc_q <= acc_nxt;
				end
				if (div_st.last) begin
					r_old_q <= r_cur_q;
					r_cur_q <= div_rem;
				end
			end
			ST_ADD: begin
				mag_old_q <= mag_cur_q;
				mag_cur_q <= acc_q + mag_old_q;
				neg_old_q <= neg_cur_q;
				neg_cur_q <= !neg_cur_q;
			end
			ST_RED: begin
				// negative coefficient maps to modulus minus its reduced magnitude, or to zero
				if (div_st.last) begin
					if (!neg_old_q) begin
						res_q.inverse <= div_rem;
					end else if (div_rem != '0) begin
						res_q.inverse <= m_q - div_rem;
					end else begin
						res_q.inverse <= '0;
					end
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/sv/modular_inverse_ext_euclid_tb.sv =====
// testbench for the extended euclid modular inverse block: directed table, random phases
`timescale 1ns / 1ps

module modular_inverse_ext_euclid_tb;
	import mie_pkg::*;

	// one row of the directed stimulus table
	typedef struct packed {
		logic [WIDTH-1:0] value;
		logic [WIDTH-1:0] modulus;
		logic             known;
		logic [WIDTH-1:0] inv;
		logic [WIDTH-1:0] gcd;
		logic             zero;
	} dir_row_t;

	localparam int RANDOM_PER_PHASE = 134;
	localparam int SETTLE_CYCLES    = 4 * WIDTH + 16;
	localparam longint unsigned WMASK = ~64'd0 >> (64 - WIDTH);

	// known answers only where they follow directly; other rows go through the predictor
	localparam int DIR_ROWS = 22;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'h0000_0001, 1'b1},
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1},
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1},
		'{32'h0000_0005, 32'h0000_0000, 1'b1, 32'h0000_0001, 32'h0000_0005, 1'b0},
		'{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'h0000_0001, 1'b0},
		'{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'h0000_0001, 1'b0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0},
		'{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 32'h0000_0001, 1'b0},
		'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'h0000_0003, 32'h0000_0007, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'h0000_0011, 32'h0000_0C30, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'h0001_0001, 32'hD4F3_A2C8, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'h0000_0064, 32'h0000_0007, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'h0000_000C, 32'h0000_0012, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'hB11924E1, 32'h6D73E55F, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'h6D73E55F, 32'hB11924E1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'h0000_0007, 32'h0000_0007, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
		'{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 1'b0}
	};

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	mie_req_t request;
	logic     busy;
	logic     done;
	mie_res_t result;

	mie_res_t pending_results [$];
	int       mismatch_count = 0;
	int       sender_idle_pct = 0;

	modular_inverse_ext_euclid uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// inverse, gcd and zero flag by extended euclid with sign-magnitude coefficients
	function automatic mie_res_t euclid_inverse(logic [WIDTH-1:0] v, logic [WIDTH-1:0] m);
		longint unsigned rem_prev, rem_now, rem_next, quo;
		longint unsigned coef_prev, coef_now, coef_next, reduced, mod64, inv;
		bit              neg_prev, neg_now;
		mie_res_t        res;
		res = '0;
		mod64 = 64'(m);
		if (v == '0) begin
			res.common_divisor = m;
			res.zero_value = 1'b1;
			return res;
		end
		rem_prev = mod64;
		rem_now = 64'(v);
		coef_prev = 0;
		coef_now = 1;
		neg_prev = 1'b0;
		neg_now = 1'b0;
		// quotient steps until the divisor reaches zero
		while (rem_now != 0) begin
			quo = rem_prev / rem_now;
			rem_next = rem_prev % rem_now;
			coef_next = (coef_prev + quo * coef_now) & WMASK;
			rem_prev = rem_now;
			rem_now = rem_next;
			coef_prev = coef_now;
			coef_now = coef_next;
			neg_prev = neg_now;
			neg_now = !neg_now;
		end
		// map the coefficient of the gcd into 0..m-1; a zero modulus keeps it unreduced
		if (mod64 == 0) begin
			inv = coef_prev;
		end else begin
			reduced = coef_prev % mod64;
			if (neg_prev && reduced != 0)
				inv = mod64 - reduced;
			else
				inv = neg_prev ? 0 : reduced;
		end
		res.inverse = inv[WIDTH-1:0];
		res.common_divisor = rem_prev[WIDTH-1:0];
		return res;
	endfunction

	// random operand pair, mixed across the interesting shapes
	function automatic mie_req_t random_request();
		mie_req_t        req;
		logic [WIDTH-1:0] mask;
		longint unsigned fa, fb, ft, g;
		int              steps;
		req.value = WIDTH'({$urandom, $urandom});
		req.modulus = WIDTH'({$urandom, $urandom});
		case ($urandom_range(9))
			0, 1: ;
			// narrow operands
			2: begin
				mask = {WIDTH{1'b1}} >> (WIDTH - $urandom_range(1, WIDTH));
				req.value = req.value & mask;
				req.modulus = req.modulus & mask;
			end
			// occasional zero value
			3: if ($urandom_range(2) == 0) req.value = '0;
			// shared factor
			4: begin
				g = $urandom_range(2, 2000);
				req.value = WIDTH'(g * $urandom_range(1, 1 << 20));
				req.modulus = WIDTH'(g * $urandom_range(1, 1 << 20));
			end
			// value above the modulus
			5: req.modulus = WIDTH'($urandom_range(1, 1 << $urandom_range(1, 24)));
			// edge moduli and values
			6: case ($urandom_range(3))
				0: req.modulus = 1;
				1: req.modulus = '1;
				2: req.value = req.modulus - 1;
				default: req.value = 1;
			endcase
			// consecutive fibonacci numbers, the longest chains
			7: begin
				fa = 1;
				fb = 1;
				steps = $urandom_range(0, 45);
				repeat (steps) begin
					ft = fa + fb;
					fa = fb;
					fb = ft;
				end
				req.value = WIDTH'(fa);
				req.modulus = WIDTH'(fb);
				if ($urandom_range(1)) begin
					req.value = WIDTH'(fb);
					req.modulus = WIDTH'(fa);
				end
			end
			// key-setup style: even totient-like modulus, small public exponent or random odd value
			default: begin
				req.modulus[0] = 1'b0;
				case ($urandom_range(3))
					0: req.value = 3;
					1: req.value = 17;
					2: req.value = 65537;
					default: req.value[0] = 1'b1;
				endcase
			end
		endcase
		if (req.modulus == '0)
			req.modulus = 1;
		return req;
	endfunction

	// hand over one request, optional sender gap first, and queue its answer
	task automatic send_request(mie_req_t req, bit known, mie_res_t known_res);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		if (known)
			pending_results.push_back(known_res);
		else
			pending_results.push_back(euclid_inverse(req.value, req.modulus));
	endtask

	// hold off new requests until every answer is back
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(string what, mie_res_t want, mie_res_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch (%s): expected inv=%h gcd=%h zero=%b, got inv=%h gcd=%h zero=%b",
				$realtime, what, want.inverse, want.common_divisor, want.zero_value,
				got.inverse, got.common_divisor, got.zero_value);
	endtask

	// result check against the oldest pending answer
	always @(posedge clk) begin
		mie_res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", '0, result);
			end else begin
				want = pending_results.pop_front();
				if (result.inverse !== want.inverse)
					report_mismatch("inverse", want, result);
				else if (result.common_divisor !== want.common_divisor)
					report_mismatch("common_divisor", want, result);
				else if (result.zero_value !== want.zero_value)
					report_mismatch("zero_value", want, result);
			end
		end
	end

	// stimulus: reset, directed table, three random phases
	initial begin
		mie_req_t req;
		mie_res_t typed;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 7;
		for (int i = 0; i < DIR_ROWS; i++) begin
			req.value = DIRECTED[i].value;
			req.modulus = DIRECTED[i].modulus;
			typed.inverse = DIRECTED[i].inv;
			typed.common_divisor = DIRECTED[i].gcd;
			typed.zero_value = DIRECTED[i].zero;
			send_request(req, DIRECTED[i].known, typed);
		end
		drain_results();

		// sender idles lightly, then heavily, then not at all
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 49 : 0;
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				send_request(random_request(), 1'b0, '0);
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// run limit, several times the slowest correct run
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
